// ----- src/htw_pkg.sv -----
package htw_pkg;

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 5;
  localparam int TMO_W       = 24;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int MS_W        = 16;
  localparam int ROUND_W     = 32;
  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;
  localparam int DIVD_W      = 25;
  localparam int DIVS_W      = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  localparam logic [KIND_W-1:0] KIND_CMD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACTIVE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

  localparam logic REG_MS_PER_TICK = 1'b0;
  localparam logic [MS_W-1:0] MS_PER_TICK_RST = 16'd1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic set_act;
    logic clr_act;
  } mem_ctl_t;

endpackage

// ----- src/htw_if.sv -----
interface htw_cmd_if import htw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     timer_id;
  logic [TMO_W-1:0]    timeout_ms;

  modport source (output valid, output action, output timer_id, output timeout_ms,
                  input ready);
  modport sink   (input valid, input action, input timer_id, input timeout_ms,
                  output ready);
endinterface

interface htw_res_if import htw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     expired_id;
  logic                last;

  modport source (output valid, output result_kind, output status, output expired_id,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input status, input expired_id,
                  input last, output ready);
endinterface

// ----- src/htw_div.sv -----
module htw_div import htw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIVD_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DIVD_W-1:0] quot;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, quot[DIVD_W-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      quot <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quot <= {quot[DIVD_W-2:0], ge};
      step <= step + STEP_W'(1);
      busy <= (step != STEP_W'(DIVD_W - 1));
      done <= (step == STEP_W'(DIVD_W - 1));
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

// ----- src/htw_mem.sv -----
module htw_mem import htw_pkg::*; #(
  parameter int NUM_TIMERS = 32,
  parameter int NUM_SLOTS  = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mem_ctl_t                     ctl,
  input  logic [$clog2(NUM_TIMERS)-1:0] rd_addr,
  input  logic [$clog2(NUM_TIMERS)-1:0] wr_addr,
  input  logic [$clog2(NUM_SLOTS)-1:0]  wr_slot,
  input  logic [ROUND_W-1:0]            wr_round,
  output logic                         rd_active,
  output logic [$clog2(NUM_SLOTS)-1:0]  rd_slot,
  output logic [ROUND_W-1:0]            rd_round
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int ENT_W  = SLOT_W + ROUND_W;

  logic [ENT_W-1:0]      ent [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active;

  // slot and round entries, undefined until written
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      ent[wr_addr] <= {wr_slot, wr_round};
    end
    if (ctl.rd) begin
      {rd_slot, rd_round} <= ent[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (ctl.set_act) begin
        active[wr_addr] <= 1'b1;
      end else if (ctl.clr_act) begin
        active[wr_addr] <= 1'b0;
      end
      if (ctl.rd) begin
        rd_active <= active[rd_addr];
      end
    end
  end

endmodule

// ----- src/hashed_timer_wheel_top.sv -----
// delete, or add of an active timer: lookup of the active bit, then the result
// add and update: lookup, then the serial divide of the timeout by ms_per_tick,
// then a reciprocal multiply splits slot and round, the entry is written, then the result
// tick: scan of all entries, then ids walked up to the highest expired id; a result
// waiting for res.ready holds the block; one item at a time; synchronous reset
// clears active bits and wheel position, sets ms_per_tick to 1, entry memory not cleared
module hashed_timer_wheel_top import htw_pkg::*; #(
  parameter int NUM_TIMERS = 32,
  parameter int NUM_SLOTS  = 64
) (
  input  logic               clk,
  input  logic               rst,
  htw_cmd_if.sink            cmd,
  htw_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(NUM_TIMERS);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int RCP_K  = DIVD_W + SLOT_W;
  // ceil(2^RCP_K / NUM_SLOTS), exact quotient for any DIVD_W-bit position
  localparam logic [DIVD_W:0] RCP =
    (DIVD_W + 1)'(((64'd1 << RCP_K) + 64'(NUM_SLOTS) - 64'd1) / 64'(NUM_SLOTS));

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOOK  = 8'b00000010,
    S_QDIV  = 8'b00000100,
    S_SDIV  = 8'b00001000,
    S_WRITE = 8'b00010000,
    S_RESP  = 8'b00100000,
    S_SCAN  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  state_t              state;
  logic [MS_W-1:0]     ms_per_tick;
  action_t             act;
  logic [IDX_W-1:0]    id;
  logic [TMO_W-1:0]    tmo;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   cur_slot;
  logic [ROUND_W-1:0]  cur_round;
  logic [IDX_W:0]      scan_idx;
  logic [IDX_W-1:0]    chk_idx;
  logic                chk_vld;
  logic [NUM_TIMERS-1:0] hits;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    emit_idx;
  logic [DIVD_W-1:0]   pos;
  logic [DIVD_W-1:0]   quo;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_id;
  logic                out_last;

  logic                out_load;
  logic [KIND_W-1:0]   out_kind_next;
  logic [STATUS_W-1:0] out_status_next;
  logic [ID_W-1:0]     out_id_next;
  logic                out_last_next;

  logic                cmd_acc;
  logic                out_free;
  logic                cfg_wr;
  logic [IDX_W-1:0]    id_map;
  logic                scan_more;
  logic                hit;
  logic                scan_end;
  logic                wheel_step;
  logic [2*DIVD_W:0]   prod;
  logic [SLOT_W-1:0]   new_slot;
  logic [ROUND_W-1:0]  new_round;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  mem_ctl_t            mem_ctl;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                rd_active;
  logic [SLOT_W-1:0]   rd_slot;
  logic [ROUND_W-1:0]  rd_round;

  htw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  htw_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_slot   (new_slot),
    .wr_round  (new_round),
    .rd_active (rd_active),
    .rd_slot   (rd_slot),
    .rd_round  (rd_round)
  );

  assign cmd.ready       = (state == S_IDLE);
  assign cmd_acc         = cmd.valid && cmd.ready;
  assign out_free        = !out_valid || res.ready;
  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.status      = out_status;
  assign res.expired_id  = out_id;
  assign res.last        = out_last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MS_PER_TICK);
  assign prdata = (paddr[PADDR_W-1] == REG_MS_PER_TICK) ? APB_DW'(ms_per_tick) : '0;

  // position split into slot and round
  assign prod      = {{(DIVD_W + 1){1'b0}}, pos} * {{DIVD_W{1'b0}}, RCP};
  assign new_slot  = SLOT_W'(pos - DIVD_W'(quo * DIVD_W'(NUM_SLOTS)));
  assign new_round = cur_round + ROUND_W'(quo);

  // timer id reduced modulo the table size
  always_comb begin
    id_map = '0;
    for (int i = 0; i < (1 << ID_W); i++) begin
      if (cmd.timer_id == ID_W'(i)) begin
        id_map = IDX_W'(i % NUM_TIMERS);
      end
    end
  end

  always_comb begin
    scan_more = scan_idx < (IDX_W + 1)'(NUM_TIMERS);
    hit = (state == S_SCAN) && chk_vld && rd_active && (rd_slot == cur_slot) &&
          (rd_round <= cur_round) && (cnt < CNT_W'(MAX_RESULTS));
    scan_end = chk_vld && (chk_idx == IDX_W'(NUM_TIMERS - 1));
  end

  always_comb begin
    mem_ctl  = '0;
    rd_addr  = id_map;
    wr_addr  = id;
    div_req  = '0;
    div_req.dividend = DIVD_W'(tmo);
    div_req.divisor  = (ms_per_tick == '0) ? DIVS_W'(1) : DIVS_W'(ms_per_tick);
    case (state)
      S_IDLE: begin
        mem_ctl.rd = cmd_acc;
      end
      S_LOOK: begin
        mem_ctl.clr_act = rd_active && (act == ACT_DELETE || act == ACT_UPDATE);
        div_req.start   = (act == ACT_UPDATE) || (act == ACT_ADD && !rd_active);
      end
      S_WRITE: begin
        mem_ctl.wr      = 1'b1;
        mem_ctl.set_act = 1'b1;
      end
      S_SCAN: begin
        mem_ctl.rd      = scan_more;
        rd_addr         = scan_idx[IDX_W-1:0];
        mem_ctl.clr_act = hit;
        wr_addr         = chk_idx;
      end
      default: begin
      end
    endcase
  end

  // result register loads
  always_comb begin
    out_load        = 1'b0;
    out_kind_next   = KIND_CMD;
    out_status_next = ST_OK;
    out_id_next     = '0;
    out_last_next   = 1'b1;
    wheel_step      = 1'b0;
    case (state)
      S_RESP: begin
        out_load        = out_free;
        out_status_next = status;
      end
      S_EMIT: begin
        if (cnt == '0) begin
          out_load      = out_free;
          out_kind_next = KIND_EMPTY;
          wheel_step    = out_free;
        end else if (hits[emit_idx]) begin
          out_load      = out_free;
          out_kind_next = KIND_EXPIRED;
          out_id_next   = ID_W'(emit_idx);
          out_last_next = (cnt == CNT_W'(1));
          wheel_step    = out_free && (cnt == CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ms_per_tick <= MS_PER_TICK_RST;
      cur_slot    <= '0;
      cur_round   <= '0;
      out_valid   <= 1'b0;
      chk_vld     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        ms_per_tick <= pwdata[MS_W-1:0];
      end

      if (out_load) begin
        out_valid  <= 1'b1;
        out_kind   <= out_kind_next;
        out_status <= out_status_next;
        out_id     <= out_id_next;
        out_last   <= out_last_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (wheel_step) begin
        if (cur_slot == SLOT_W'(NUM_SLOTS - 1)) begin
          cur_slot  <= '0;
          cur_round <= cur_round + ROUND_W'(1);
        end else begin
          cur_slot <= cur_slot + SLOT_W'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            act <= action_t'(cmd.action);
            id  <= id_map;
            tmo <= cmd.timeout_ms;
            if (action_t'(cmd.action) == ACT_TICK) begin
              scan_idx <= '0;
              chk_vld  <= 1'b0;
              hits     <= '0;
              cnt      <= '0;
              state    <= S_SCAN;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (act == ACT_DELETE) begin
            status <= rd_active ? ST_OK : ST_NOT_ACTIVE;
            state  <= S_RESP;
          end else if (act == ACT_ADD && rd_active) begin
            status <= ST_ACTIVE;
            state  <= S_RESP;
          end else begin
            state <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_rsp.done) begin
            pos   <= DIVD_W'(cur_slot) + div_rsp.quot;
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          quo   <= DIVD_W'(prod >> RCP_K);
          state <= S_WRITE;
        end
        S_WRITE: begin
          status <= ST_OK;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            scan_idx <= scan_idx + (IDX_W + 1)'(1);
          end
          chk_vld <= scan_more;
          chk_idx <= scan_idx[IDX_W-1:0];
          if (hit) begin
            hits[chk_idx] <= 1'b1;
            cnt           <= cnt + CNT_W'(1);
          end
          if (scan_end) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (cnt == '0) begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end else if (hits[emit_idx]) begin
            if (out_free) begin
              cnt      <= cnt - CNT_W'(1);
              emit_idx <= emit_idx + IDX_W'(1);
              if (cnt == CNT_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end else begin
            emit_idx <= emit_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/hashed_timer_wheel_top_tb.sv -----
`timescale 1ns / 1ps

module hashed_timer_wheel_top_tb import htw_pkg::*;;

  localparam int NUM_TIMERS   = 32;
  localparam int NUM_SLOTS    = 64;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int RUN_LIMIT_NS = 4_000_000;
  localparam int TMO_MAX      = (1 << TMO_W) - 1;
  localparam logic [ID_W-1:0] ID_MAX = ID_W'(NUM_TIMERS - 1);
  localparam logic [PADDR_W-1:0] TICK_LEN_ADDR = PADDR_W'(4 * int'(REG_MS_PER_TICK));
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4 * (int'(REG_MS_PER_TICK) + 1));

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic                last;
  } wheel_report_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic pready;

  htw_cmd_if cmd_if();
  htw_res_if res_if();

  hashed_timer_wheel_top #(
    .NUM_TIMERS(NUM_TIMERS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if.sink),
    .res    (res_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predicted wheel state
  logic [MS_W-1:0]    tick_len = MS_PER_TICK_RST;
  logic               armed [NUM_TIMERS];
  logic [SLOT_W-1:0]  due_slot [NUM_TIMERS];
  logic [ROUND_W-1:0] due_round [NUM_TIMERS];
  logic [SLOT_W-1:0]  wheel_slot = '0;
  logic [ROUND_W-1:0] wheel_round = '0;
  wheel_report_t      due_reports[$];

  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_start = 0;
  int unsigned hold_left = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  function automatic logic [STATUS_W-1:0] arm_timer(input logic [ID_W-1:0] id,
                                                     input logic [TMO_W-1:0] tmo);
    logic [31:0] divisor;
    logic [31:0] pos;
    if (armed[id]) return ST_ACTIVE;
    divisor = (tick_len == '0) ? 32'd1 : 32'(tick_len);
    pos = 32'(wheel_slot) + 32'(tmo) / divisor;
    due_slot[id] = SLOT_W'(pos % NUM_SLOTS);
    due_round[id] = wheel_round + pos / NUM_SLOTS;
    armed[id] = 1'b1;
    return ST_OK;
  endfunction

  function automatic void wheel_apply(input action_t act, input logic [ID_W-1:0] id,
                                      input logic [TMO_W-1:0] tmo);
    wheel_report_t r;
    int unsigned hits;
    r.kind = KIND_CMD;
    r.status = ST_OK;
    r.id = '0;
    r.last = 1'b1;
    if (act != ACT_TICK) begin
      case (act)
        ACT_ADD: r.status = arm_timer(id, tmo);
        ACT_UPDATE: begin
          armed[id] = 1'b0;
          r.status = arm_timer(id, tmo);
        end
        default: begin
          r.status = armed[id] ? ST_OK : ST_NOT_ACTIVE;
          armed[id] = 1'b0;
        end
      endcase
      due_reports.push_back(r);
      return;
    end
    hits = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed[i] && due_slot[i] == wheel_slot && due_round[i] <= wheel_round &&
          hits < MAX_RESULTS) begin
        armed[i] = 1'b0;
        r.kind = KIND_EXPIRED;
        r.id = ID_W'(i);
        r.last = 1'b0;
        due_reports.push_back(r);
        hits++;
      end
    end
    if (hits == 0) begin
      r.kind = KIND_EMPTY;
      due_reports.push_back(r);
    end else begin
      r = due_reports.pop_back();
      r.last = 1'b1;
      due_reports.push_back(r);
    end
    wheel_slot = SLOT_W'((wheel_slot + 1) % NUM_SLOTS);
    if (wheel_slot == '0) wheel_round++;
  endfunction

  task automatic check_report(input wheel_report_t got);
    wheel_report_t want;
    if (due_reports.size() == 0) begin
      report_mismatch("result with nothing pending, result_kind", 0, got.kind);
    end else begin
      want = due_reports.pop_front();
      if (got.kind !== want.kind) report_mismatch("result_kind", want.kind, got.kind);
      if (got.status !== want.status) report_mismatch("status", want.status, got.status);
      if (got.id !== want.id) report_mismatch("expired_id", want.id, got.id);
      if (got.last !== want.last) report_mismatch("last", want.last, got.last);
    end
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_report({res_if.result_kind, res_if.status, res_if.expired_id, res_if.last});
      end
      if (hold_start != 0) begin
        hold_left = hold_start;
        hold_start = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                           input logic [TMO_W-1:0] tmo);
    if ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= act;
    cmd_if.timer_id <= id;
    cmd_if.timeout_ms <= tmo;
    do @(posedge clk); while (!cmd_if.ready);
    wheel_apply(act, id, tmo);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write_read(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TICK_LEN_ADDR) tick_len = data[MS_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == TICK_LEN_ADDR && prdata[MS_W-1:0] !== tick_len) begin
      report_mismatch("ms_per_tick readback", tick_len, prdata[MS_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short timeouts so timers actually expire during the run
  function automatic logic [TMO_W-1:0] pick_timeout();
    int unsigned divisor;
    int unsigned t;
    if ($urandom_range(9) == 0) return TMO_W'($urandom);
    divisor = (tick_len == '0) ? 1 : int'(tick_len);
    t = $urandom_range(70) * divisor + $urandom_range(divisor - 1);
    if (t > TMO_MAX) t = TMO_MAX;
    return TMO_W'(t);
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    int unsigned pick;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (n_items) begin
      if ($urandom_range(99) < 4) wait_drained();
      pick = $urandom_range(99);
      if (pick < 45) send_item(ACT_TICK, ID_W'($urandom), TMO_W'($urandom));
      else if (pick < 70) send_item(ACT_ADD, ID_W'($urandom), pick_timeout());
      else if (pick < 85) send_item(ACT_UPDATE, ID_W'($urandom), pick_timeout());
      else send_item(ACT_DELETE, ID_W'($urandom), TMO_W'($urandom));
    end
    wait_drained();
  endtask

  // every entry gets written, then one tick expires all of them at once
  task automatic test_full_slot();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) send_item(ACT_ADD, ID_W'(i), '0);
    send_item(ACT_TICK, '0, '0);
    wait_drained();
  endtask

  task automatic test_commands();
    send_item(ACT_ADD, '0, TMO_W'(TMO_MAX));
    send_item(ACT_ADD, '0, TMO_W'(5));
    send_item(ACT_UPDATE, '0, '0);
    send_item(ACT_DELETE, ID_MAX, '0);
    send_item(ACT_UPDATE, ID_MAX, TMO_W'(1));
    send_item(ACT_DELETE, ID_MAX, TMO_W'(TMO_MAX));
    send_item(ACT_TICK, ID_MAX, TMO_W'(TMO_MAX));
    send_item(ACT_DELETE, '0, '0);
    wait_drained();
  endtask

  // same slot one round ahead must not fire
  task automatic test_round_compare();
    send_item(ACT_ADD, ID_W'(5), TMO_W'(NUM_SLOTS));
    send_item(ACT_ADD, ID_W'(6), '0);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_TICK, '0, '0);
    wait_drained();
  endtask

  task automatic test_tick_length();
    apb_write_read(TICK_LEN_ADDR, 32'hFFFF_FFFF);
    apb_write_read(UNMAPPED_ADDR, APB_DW'($urandom));
    send_item(ACT_ADD, ID_W'(7), TMO_W'(TMO_MAX));
    send_item(ACT_ADD, ID_W'(8), TMO_W'(65534));
    send_item(ACT_ADD, ID_W'(10), TMO_W'(2 * 65535));
    send_item(ACT_TICK, '0, '0);
    wait_drained();
    // zero tick length behaves as one
    apb_write_read(TICK_LEN_ADDR, 32'h0001_0000);
    send_item(ACT_ADD, ID_W'(9), TMO_W'(3));
    repeat (4) send_item(ACT_TICK, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    apb_write_read(TICK_LEN_ADDR, 32'd1);
    run_random(20, 0, 0);
    apb_write_read(TICK_LEN_ADDR, APB_DW'($urandom_range(300, 2)));
    run_random(20, 67, 0);
    apb_write_read(TICK_LEN_ADDR, APB_DW'($urandom) | 32'h0000_FFFF);
    run_random(20, 0, 67);
    apb_write_read(TICK_LEN_ADDR, APB_DW'($urandom) & 32'hFFFF_0000);
    run_random(20, 24, 24);
  endtask

  // results held off long enough for the block to stop taking items
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    apb_write_read(TICK_LEN_ADDR, 32'd1);
    hold_start = 400;
    for (int k = 0; k < 24; k++) begin
      if (k % 3 == 2) send_item(ACT_TICK, ID_W'($urandom), TMO_W'($urandom));
      else send_item(ACT_ADD, ID_W'($urandom), TMO_W'($urandom_range(3)));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_ADD;
    cmd_if.timer_id = '0;
    cmd_if.timeout_ms = '0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_full_slot();
    test_commands();
    test_round_compare();
    test_tick_length();
    test_random_traffic();
    test_backpressure();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- hashed_timer_wheel_top.f -----
src/htw_pkg.sv
src/htw_if.sv
src/htw_div.sv
src/htw_mem.sv
src/hashed_timer_wheel_top.sv
tb/hashed_timer_wheel_top_tb.sv
